// ----- rtl/qjt_pkg.sv -----
`default_nettype none

package qjt_pkg;

  localparam int AXES_DEF = 6;

  localparam int MUL_AW  = 36;
  localparam int MUL_BW  = 32;
  localparam int DIV_NW  = 64;
  localparam int DIV_DW  = 48;
  localparam int SQRT_XW = 64;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_START,
    CMD_TICK,
    CMD_STOP
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_INVALID,
    STAT_NOT_READY,
    STAT_LIMIT
  } status_e;

endpackage

`default_nettype wire

// ----- rtl/qjt_mul.sv -----
`default_nettype none

module qjt_mul
  import qjt_pkg::*;
#(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW);

  logic [PW-1:0] a_q, acc_q;
  logic [BW-1:0] b_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(BW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= PW'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// ----- rtl/qjt_div.sv -----
`default_nettype none

module qjt_div
  import qjt_pkg::*;
#(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o,
  output logic          rem_nz_o
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] n_q;
  logic [DW-1:0] d_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_q, n_q[NW-1]};
  assign ge    = trial >= {1'b0, d_q};
  assign diff  = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      n_q   <= num_i;
      d_q   <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      n_q   <= {n_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done_o   = done_q;
  assign quot_o   = n_q;
  assign rem_nz_o = |rem_q;

endmodule

`default_nettype wire

// ----- rtl/qjt_sqrt.sv -----
`default_nettype none

module qjt_sqrt
  import qjt_pkg::*;
#(
  parameter int XW = SQRT_XW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [XW-1:0]   x_i,
  output logic            done_o,
  output logic [XW/2-1:0] root_o,
  output logic            rem_nz_o
);

  localparam int RTW = XW / 2;
  localparam int RW  = RTW + 2;
  localparam int CW  = $clog2(RTW);

  logic [XW-1:0]  x_q;
  logic [RTW-1:0] root_q;
  logic [RW-1:0]  rem_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;
  logic [RW+1:0]  remx, trial, diff;
  logic           ge;

  assign remx  = {rem_q, x_q[XW-1:XW-2]};
  assign trial = (RW + 2)'({root_q, 2'b01});
  assign ge    = remx >= trial;
  assign diff  = remx - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(RTW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      x_q    <= x_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      x_q    <= x_q << 2;
      root_q <= {root_q[RTW-2:0], ge};
      rem_q  <= ge ? diff[RW-1:0] : remx[RW-1:0];
    end
  end

  assign done_o   = done_q;
  assign root_o   = root_q;
  assign rem_nz_o = |rem_q;

endmodule

`default_nettype wire

// ----- rtl/quintic_joint_trajectory_generator.sv -----
`default_nettype none

// Channel  Handshake                   Payload
// in       in_valid_i / in_stall_o     cmd_i, axis_i, start_pos_i .. time_value_i
// out      out_valid_o / out_stall_i   out_axis_o, position_o .. last_o
//
// Load and stop items go straight to the emit state. A start item runs the checks over
// all axes, then the divide, multiply, divide and square root steps for each axis. A
// tick uses the bit-serial multiplier and divider that all steps share, then emits one
// result per axis. Reset clears the axis tables, the timing state and the flags. A
// stalled output holds the last result; new items are taken only while the sequencer
// is idle.

module quintic_joint_trajectory_generator
  import qjt_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [2:0]         axis_i,
  input  logic signed [23:0] start_pos_i,
  input  logic signed [23:0] target_pos_i,
  input  logic [23:0]        max_vel_i,
  input  logic [23:0]        max_acc_i,
  input  logic signed [23:0] pos_min_i,
  input  logic signed [23:0] pos_max_i,
  input  logic [31:0]        time_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_axis_o,
  output logic signed [23:0] position_o,
  output logic signed [31:0] velocity_o,
  output logic signed [31:0] acceleration_o,
  output logic [1:0]         status_o,
  output logic               finished_o,
  output logic               last_o
);

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [AW-1:0] LAST_AX = AW'(AXES - 1);
  localparam int PW = MUL_AW + MUL_BW;

  localparam logic [28:0] Q_ONE    = 29'h1000_0000;
  localparam logic [32:0] Q_TEN    = 33'h0_A000_0000;
  localparam logic [31:0] ACC_K    = 32'd6053956;
  localparam logic [31:0] MIN_TIME = 32'd66;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_EMIT1 = 5'd1;
  localparam logic [4:0] S_CHK   = 5'd2;
  localparam logic [4:0] S_WAIT  = 5'd3;
  localparam logic [4:0] S_ST1   = 5'd4;
  localparam logic [4:0] S_ST2   = 5'd5;
  localparam logic [4:0] S_ST3   = 5'd6;
  localparam logic [4:0] S_ST4   = 5'd7;
  localparam logic [4:0] S_ST5   = 5'd8;
  localparam logic [4:0] S_TK0   = 5'd9;
  localparam logic [4:0] S_TK1   = 5'd10;
  localparam logic [4:0] S_TK2   = 5'd11;
  localparam logic [4:0] S_TK3   = 5'd12;
  localparam logic [4:0] S_TK4   = 5'd13;
  localparam logic [4:0] S_TK5   = 5'd14;
  localparam logic [4:0] S_TK6   = 5'd15;
  localparam logic [4:0] S_TK7   = 5'd16;
  localparam logic [4:0] S_TK8   = 5'd17;
  localparam logic [4:0] S_AX0   = 5'd18;
  localparam logic [4:0] S_AX1   = 5'd19;
  localparam logic [4:0] S_AX2   = 5'd20;
  localparam logic [4:0] S_AX3   = 5'd21;
  localparam logic [4:0] S_AX4   = 5'd22;
  localparam logic [4:0] S_AX5   = 5'd23;
  localparam logic [4:0] S_AX6   = 5'd24;
  localparam logic [4:0] S_TEMIT = 5'd25;

  function automatic logic in_bnd(input logic signed [23:0] p, input logic signed [23:0] lo,
                                  input logic signed [23:0] hi);
    return (p >= lo) && (p <= hi);
  endfunction

  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic [63:0] m;
    if (neg) begin
      m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
      return 32'd0 - m[31:0];
    end
    m = (mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag;
    return m[31:0];
  endfunction

  // Axis tables.
  logic signed [23:0] st_q [AXES];
  logic signed [23:0] tg_q [AXES];
  logic [23:0]        vl_q [AXES];
  logic [23:0]        al_q [AXES];
  logic signed [23:0] bl_q [AXES];
  logic signed [23:0] bh_q [AXES];

  // Result buffers for one tick.
  logic signed [23:0] pos_buf [AXES];
  logic [31:0]        vel_buf [AXES];
  logic [31:0]        acc_buf [AXES];

  logic [4:0]    state_q, state_d, ret_q, ret_d;
  logic [AW-1:0] ax_q, ax_d, oi_q, oi_d;
  logic          running_q, running_d, done_q, done_d;
  logic [31:0]   total_q, total_d, elapsed_q, elapsed_d;
  logic          lim_bad_q, lim_bad_d, bnd_bad_q, bnd_bad_d, viol_q, viol_d;
  logic [31:0]   tval_q, tval_d, dur_q, dur_d;
  logic [2:0]    res_axis_q, res_axis_d;
  status_e       res_stat_q, res_stat_d;
  logic [28:0]   u_q, u_d, u2_q, u2_d, s_q, s_d, g_q, g_d, h_q, h_d;

  logic          load_we, pos_we, vel_we, acc_we;
  logic          out_load, out_free, out_valid_q;
  logic [AW-1:0] ld_idx;
  logic          ld_ok;

  logic              mul_go, mul_done;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PW-1:0]     mul_p;
  logic              div_go, div_done, div_rnz;
  logic [DIV_NW-1:0] div_n, div_q;
  logic [DIV_DW-1:0] div_d;
  logic                 sqrt_go, sqrt_done, sqrt_rnz;
  logic [SQRT_XW-1:0]   sqrt_x;
  logic [SQRT_XW/2-1:0] sqrt_root;

  // Current axis.
  logic signed [23:0] cur_st, cur_tg, cur_bl, cur_bh;
  logic [23:0]        cur_vl, cur_al;
  logic signed [24:0] diff;
  logic               neg;
  logic [24:0]        ad;
  logic [28:0]        ad15;
  logic [29:0]        ad30;
  logic [34:0]        ad960;

  assign cur_st = st_q[ax_q];
  assign cur_tg = tg_q[ax_q];
  assign cur_vl = vl_q[ax_q];
  assign cur_al = al_q[ax_q];
  assign cur_bl = bl_q[ax_q];
  assign cur_bh = bh_q[ax_q];
  assign diff   = {cur_tg[23], cur_tg} - {cur_st[23], cur_st};
  assign neg    = diff[24];
  assign ad     = neg ? 25'(-diff) : 25'(diff);
  assign ad15   = 29'({ad, 4'b0}) - 29'(ad);
  assign ad30   = 30'({ad, 5'b0}) - 30'({ad, 1'b0});
  assign ad960  = 35'({ad, 10'b0}) - 35'({ad, 6'b0});

  // Derived values from the shared units.
  logic [63:0] div_qc;
  logic [31:0] tv32, dur_tv, ta32, dur_ta, dur_fin;
  logic [32:0] ta33, esum;
  logic [31:0] e_clamp;
  logic [28:0] u_new, mp_hi, v_val, w_val;
  logic [32:0] s_full, p_add, u15, poly;
  logic [29:0] u2x;
  logic        wneg;
  logic [24:0] pm, delta, pos25;
  logic signed [23:0] pos_new;
  logic [31:0] vel_new, acc_new;

  assign div_qc  = div_q + 64'(div_rnz);
  assign tv32    = (|div_qc[63:32]) ? 32'hFFFF_FFFF : div_qc[31:0];
  assign dur_tv  = (tv32 > dur_q) ? tv32 : dur_q;
  assign ta33    = 33'(sqrt_root) + 33'(sqrt_rnz);
  assign ta32    = ta33[32] ? 32'hFFFF_FFFF : ta33[31:0];
  assign dur_ta  = (ta32 > dur_q) ? ta32 : dur_q;
  assign dur_fin = (dur_ta < MIN_TIME) ? MIN_TIME : dur_ta;

  assign esum    = 33'(elapsed_q) + 33'(tval_q);
  assign e_clamp = (esum > 33'(total_q)) ? total_q : esum[31:0];
  assign u_new   = (total_q == 32'd0) ? Q_ONE : div_q[28:0];
  assign mp_hi   = mul_p[56:28];
  assign s_full  = mul_p[60:28];
  assign v_val   = Q_ONE - u_q;
  assign p_add   = Q_TEN + 33'({u2_q, 2'b0}) + 33'({u2_q, 1'b0});
  assign u15     = 33'({u_q, 4'b0}) - 33'(u_q);
  assign poly    = (p_add > u15) ? (p_add - u15) : 33'd0;
  assign u2x     = {u_q, 1'b0};
  assign wneg    = u2x > {1'b0, Q_ONE};
  assign w_val   = wneg ? 29'(u2x - {1'b0, Q_ONE}) : 29'({1'b0, Q_ONE} - u2x);

  assign pm      = mul_p[52:28];
  assign delta   = neg ? (25'd0 - pm) : pm;
  assign pos25   = {cur_st[23], cur_st} + delta;
  assign pos_new = (u_q == Q_ONE) ? cur_tg : pos25[23:0];
  assign vel_new = (total_q == 32'd0) ? 32'd0 : sat32(neg, div_q);
  assign acc_new = (total_q == 32'd0) ? 32'd0 : sat32(neg ^ wneg, div_q);

  assign ld_idx = AW'(axis_i);
  assign ld_ok  = {2'b00, axis_i} < 5'(AXES);

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    ax_d       = ax_q;
    oi_d       = oi_q;
    running_d  = running_q;
    done_d     = done_q;
    total_d    = total_q;
    elapsed_d  = elapsed_q;
    lim_bad_d  = lim_bad_q;
    bnd_bad_d  = bnd_bad_q;
    viol_d     = viol_q;
    tval_d     = tval_q;
    dur_d      = dur_q;
    res_axis_d = res_axis_q;
    res_stat_d = res_stat_q;
    u_d        = u_q;
    u2_d       = u2_q;
    s_d        = s_q;
    g_d        = g_q;
    h_d        = h_q;
    load_we    = 1'b0;
    pos_we     = 1'b0;
    vel_we     = 1'b0;
    acc_we     = 1'b0;
    out_load   = 1'b0;
    mul_go     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_go     = 1'b0;
    div_n      = '0;
    div_d      = '0;
    sqrt_go    = 1'b0;
    sqrt_x     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tval_d     = time_value_i;
          res_axis_d = 3'd0;
          res_stat_d = STAT_OK;
          ax_d       = '0;
          case (cmd_e'(cmd_i))
            CMD_LOAD: begin
              res_axis_d = axis_i;
              if (ld_ok) begin
                load_we = 1'b1;
              end else begin
                res_stat_d = STAT_INVALID;
              end
              state_d = S_EMIT1;
            end
            CMD_START: begin
              lim_bad_d = 1'b0;
              bnd_bad_d = 1'b0;
              state_d   = S_CHK;
            end
            CMD_TICK: begin
              if (running_q || done_q) begin
                state_d = S_TK0;
              end else begin
                res_stat_d = STAT_NOT_READY;
                state_d    = S_EMIT1;
              end
            end
            default: begin
              running_d = 1'b0;
              done_d    = 1'b0;
              state_d   = S_EMIT1;
            end
          endcase
        end
      end
      S_EMIT1: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_CHK: begin
        lim_bad_d = lim_bad_q | (cur_vl == 24'd0) | (cur_al == 24'd0);
        bnd_bad_d = bnd_bad_q | !in_bnd(cur_st, cur_bl, cur_bh)
                              | !in_bnd(cur_tg, cur_bl, cur_bh);
        if (ax_q == LAST_AX) begin
          ax_d = '0;
          if (lim_bad_d) begin
            res_stat_d = STAT_INVALID;
            state_d    = S_EMIT1;
          end else if (bnd_bad_d) begin
            res_stat_d = STAT_LIMIT;
            state_d    = S_EMIT1;
          end else begin
            dur_d   = tval_q;
            state_d = S_ST1;
          end
        end else begin
          ax_d = ax_q + 1'b1;
        end
      end
      S_WAIT: begin
        if (mul_done || div_done || sqrt_done) begin
          state_d = ret_q;
        end
      end
      S_ST1: begin
        div_go  = 1'b1;
        div_n   = 64'({ad15, 13'b0});
        div_d   = DIV_DW'(cur_vl);
        ret_d   = S_ST2;
        state_d = S_WAIT;
      end
      S_ST2: begin
        dur_d   = dur_tv;
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(ad);
        mul_b   = MUL_BW'(ACC_K);
        ret_d   = S_ST3;
        state_d = S_WAIT;
      end
      S_ST3: begin
        div_go  = 1'b1;
        div_n   = {mul_p[51:0], 12'b0};
        div_d   = DIV_DW'(cur_al);
        ret_d   = S_ST4;
        state_d = S_WAIT;
      end
      S_ST4: begin
        sqrt_go = 1'b1;
        sqrt_x  = div_qc;
        ret_d   = S_ST5;
        state_d = S_WAIT;
      end
      S_ST5: begin
        if (ax_q == LAST_AX) begin
          ax_d       = '0;
          total_d    = dur_fin;
          elapsed_d  = 32'd0;
          running_d  = 1'b1;
          done_d     = 1'b0;
          res_stat_d = STAT_OK;
          state_d    = S_EMIT1;
        end else begin
          dur_d   = dur_ta;
          ax_d    = ax_q + 1'b1;
          state_d = S_ST1;
        end
      end
      S_TK0: begin
        elapsed_d = e_clamp;
        if (total_q == 32'd0) begin
          state_d = S_TK1;
        end else begin
          div_go  = 1'b1;
          div_n   = {4'b0, e_clamp, 28'b0};
          div_d   = DIV_DW'(total_q);
          ret_d   = S_TK1;
          state_d = S_WAIT;
        end
      end
      S_TK1: begin
        u_d     = u_new;
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(u_new);
        mul_b   = MUL_BW'(u_new);
        ret_d   = S_TK2;
        state_d = S_WAIT;
      end
      S_TK2: begin
        u2_d    = mp_hi;
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(mp_hi);
        mul_b   = MUL_BW'(u_q);
        ret_d   = S_TK3;
        state_d = S_WAIT;
      end
      S_TK3: begin
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(mp_hi);
        mul_b   = poly[31:0];
        ret_d   = S_TK4;
        state_d = S_WAIT;
      end
      S_TK4: begin
        s_d     = (s_full > 33'(Q_ONE)) ? Q_ONE : s_full[28:0];
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(v_val);
        mul_b   = MUL_BW'(v_val);
        ret_d   = S_TK5;
        state_d = S_WAIT;
      end
      S_TK5: begin
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(u2_q);
        mul_b   = MUL_BW'(mp_hi);
        ret_d   = S_TK6;
        state_d = S_WAIT;
      end
      S_TK6: begin
        g_d     = mp_hi;
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(u_q);
        mul_b   = MUL_BW'(v_val);
        ret_d   = S_TK7;
        state_d = S_WAIT;
      end
      S_TK7: begin
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(mp_hi);
        mul_b   = MUL_BW'(w_val);
        ret_d   = S_TK8;
        state_d = S_WAIT;
      end
      S_TK8: begin
        h_d     = mp_hi;
        ax_d    = '0;
        viol_d  = 1'b0;
        state_d = S_AX0;
      end
      S_AX0: begin
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(ad);
        mul_b   = MUL_BW'(s_q);
        ret_d   = S_AX1;
        state_d = S_WAIT;
      end
      S_AX1: begin
        pos_we  = 1'b1;
        viol_d  = viol_q | !in_bnd(pos_new, cur_bl, cur_bh);
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(ad30);
        mul_b   = MUL_BW'(g_q);
        ret_d   = S_AX2;
        state_d = S_WAIT;
      end
      S_AX2: begin
        div_go  = 1'b1;
        div_n   = mul_p[63:0];
        div_d   = DIV_DW'({total_q, 12'b0});
        ret_d   = S_AX3;
        state_d = S_WAIT;
      end
      S_AX3: begin
        vel_we  = 1'b1;
        mul_go  = 1'b1;
        mul_a   = MUL_AW'(ad960);
        mul_b   = MUL_BW'(h_q);
        ret_d   = S_AX4;
        state_d = S_WAIT;
      end
      S_AX4: begin
        div_go  = 1'b1;
        div_n   = mul_p[63:0];
        div_d   = DIV_DW'(total_q);
        ret_d   = S_AX5;
        state_d = S_WAIT;
      end
      S_AX5: begin
        div_go  = 1'b1;
        div_n   = div_q;
        div_d   = DIV_DW'(total_q);
        ret_d   = S_AX6;
        state_d = S_WAIT;
      end
      S_AX6: begin
        acc_we = 1'b1;
        if (ax_q == LAST_AX) begin
          if (viol_q) begin
            running_d = 1'b0;
            done_d    = 1'b0;
          end else if (u_q == Q_ONE) begin
            running_d = 1'b0;
            done_d    = 1'b1;
          end
          ax_d    = '0;
          oi_d    = '0;
          state_d = S_TEMIT;
        end else begin
          ax_d    = ax_q + 1'b1;
          state_d = S_AX0;
        end
      end
      S_TEMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (oi_q == LAST_AX) begin
            oi_d    = '0;
            state_d = S_IDLE;
          end else begin
            oi_d = oi_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      ax_q        <= '0;
      oi_q        <= '0;
      running_q   <= 1'b0;
      done_q      <= 1'b0;
      total_q     <= '0;
      elapsed_q   <= '0;
      lim_bad_q   <= 1'b0;
      bnd_bad_q   <= 1'b0;
      viol_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        st_q[i] <= '0;
        tg_q[i] <= '0;
        vl_q[i] <= '0;
        al_q[i] <= '0;
        bl_q[i] <= '0;
        bh_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      ax_q      <= ax_d;
      oi_q      <= oi_d;
      running_q <= running_d;
      done_q    <= done_d;
      total_q   <= total_d;
      elapsed_q <= elapsed_d;
      lim_bad_q <= lim_bad_d;
      bnd_bad_q <= bnd_bad_d;
      viol_q    <= viol_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_we) begin
        st_q[ld_idx] <= start_pos_i;
        tg_q[ld_idx] <= target_pos_i;
        vl_q[ld_idx] <= max_vel_i;
        al_q[ld_idx] <= max_acc_i;
        bl_q[ld_idx] <= pos_min_i;
        bh_q[ld_idx] <= pos_max_i;
      end
    end
  end

  logic               from_buf;
  logic [2:0]         o_axis;
  logic signed [23:0] o_pos;
  logic [31:0]        o_vel, o_acc;
  logic [1:0]         o_stat;
  logic               o_last;

  assign from_buf = (state_q == S_TEMIT);
  assign o_axis   = from_buf ? 3'(oi_q) : res_axis_q;
  assign o_pos    = from_buf ? pos_buf[oi_q] : 24'sd0;
  assign o_vel    = from_buf ? vel_buf[oi_q] : 32'd0;
  assign o_acc    = from_buf ? acc_buf[oi_q] : 32'd0;
  assign o_stat   = from_buf ? (viol_q ? STAT_LIMIT : STAT_OK) : res_stat_q;
  assign o_last   = from_buf ? (oi_q == LAST_AX) : 1'b1;

  always_ff @(posedge clk_i) begin
    tval_q     <= tval_d;
    dur_q      <= dur_d;
    res_axis_q <= res_axis_d;
    res_stat_q <= res_stat_d;
    u_q        <= u_d;
    u2_q       <= u2_d;
    s_q        <= s_d;
    g_q        <= g_d;
    h_q        <= h_d;
    if (pos_we) begin
      pos_buf[ax_q] <= pos_new;
    end
    if (vel_we) begin
      vel_buf[ax_q] <= vel_new;
    end
    if (acc_we) begin
      acc_buf[ax_q] <= acc_new;
    end
    if (out_load) begin
      out_axis_o     <= o_axis;
      position_o     <= o_pos;
      velocity_o     <= o_vel;
      acceleration_o <= o_acc;
      status_o       <= o_stat;
      finished_o     <= done_q;
      last_o         <= o_last;
    end
  end

  assign out_valid_o = out_valid_q;

  qjt_mul #(
    .AW(MUL_AW),
    .BW(MUL_BW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  qjt_div #(
    .NW(DIV_NW),
    .DW(DIV_DW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (div_go),
    .num_i    (div_n),
    .den_i    (div_d),
    .done_o   (div_done),
    .quot_o   (div_q),
    .rem_nz_o (div_rnz)
  );

  qjt_sqrt #(
    .XW(SQRT_XW)
  ) u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (sqrt_go),
    .x_i      (sqrt_x),
    .done_o   (sqrt_done),
    .root_o   (sqrt_root),
    .rem_nz_o (sqrt_rnz)
  );

endmodule

`default_nettype wire
